/* hdl/bst_pkg.sv */
// Shared types and constants for the bounded set table.
package bst_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned CountFieldW = 5;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } bst_op_e;

  // Broadcast from the controller to every cell in the chain.
  typedef struct packed {
    logic              ins_en;
    logic              rem_en;
    logic [ValueW-1:0] value;
  } bst_cmd_t;

endpackage

/* hdl/bst_cell.sv */
// One slot of the set: holds an entry, compares it and shifts from its upper neighbor.
module bst_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                           clk_i,
  input  bst_pkg::bst_cmd_t              cmd_i,
  input  logic [CNT_W-1:0]               count_i,
  input  logic [bst_pkg::ValueW-1:0]     next_i,
  input  logic                           hit_i,
  output logic                           hit_o,
  output logic [bst_pkg::ValueW-1:0]     entry_o
);

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

  logic [bst_pkg::ValueW-1:0] entry_q;
  logic                       occ;
  logic                       match;

  assign occ     = IdxC < count_i;
  assign match   = occ && (entry_q == cmd_i.value);
  // Ripples up the chain: set at the matching slot and every slot above it.
  assign hit_o   = hit_i || match;
  assign entry_o = entry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_en && (count_i == IdxC)) begin
      entry_q <= cmd_i.value;
    end else if (cmd_i.rem_en && hit_o) begin
      entry_q <= next_i;
    end
  end

endmodule

/* hdl/bounded_set_table.sv */
// Top level of the bounded set table: controller, cell chain and output register.
// A set of up to CAPACITY distinct 32-bit values in insertion order, one slot per
// cell. Every operation (query, insert, remove, clear) completes in the cycle that
// accepts it, with its result registered onto m_axis at that edge, and a new item is
// accepted every cycle while the output is taken or empty. The cycle is set by the
// parallel compare in all cells plus the match flag rippling through the chain;
// a remove shifts all later cells down one place in that same cycle. No clearing
// pass is needed after reset.
module bounded_set_table #(
  parameter int unsigned CAPACITY = bst_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] ok, [5:1] count, [6] empty_res, [7] full_res
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  logic [CntW-1:0]                count_q, count_d;
  logic                           m_valid_q;
  logic [7:0]                     m_data_q;
  logic                           acc;
  logic                           found;
  logic                           full;
  logic                           ok_d;
  logic [CntW+bst_pkg::CountFieldW-1:0] cnt_wide;
  bst_pkg::bst_op_e               op;
  bst_pkg::bst_cmd_t              cmd;
  logic [CAPACITY:0]              hit;
  logic [bst_pkg::ValueW-1:0]     ent [CAPACITY];

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign op            = bst_pkg::bst_op_e'(s_axis_tuser);
  assign full          = count_q == CapC;
  assign hit[0]        = 1'b0;
  assign found         = hit[CAPACITY];

  always_comb begin
    count_d    = count_q;
    ok_d       = 1'b0;
    cmd.ins_en = 1'b0;
    cmd.rem_en = 1'b0;
    cmd.value  = s_axis_tdata;
    case (op)
      bst_pkg::OP_QUERY: begin
        ok_d = found;
      end
      bst_pkg::OP_INSERT: begin
        if (!full && !found) begin
          ok_d       = 1'b1;
          cmd.ins_en = acc;
          count_d    = count_q + CntW'(1);
        end
      end
      bst_pkg::OP_REMOVE: begin
        if (found) begin
          ok_d       = 1'b1;
          cmd.rem_en = acc;
          count_d    = count_q - CntW'(1);
        end
      end
      bst_pkg::OP_CLEAR: begin
        ok_d    = 1'b1;
        count_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  assign cnt_wide = {{bst_pkg::CountFieldW{1'b0}}, count_d};

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [bst_pkg::ValueW-1:0] nxt;
    if (k == CAPACITY - 1) begin : g_top
      assign nxt = ent[k];
    end else begin : g_mid
      assign nxt = ent[k+1];
    end
    bst_cell #(
      .IDX   (k),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count_q),
      .next_i  (nxt),
      .hit_i   (hit[k]),
      .hit_o   (hit[k+1]),
      .entry_o (ent[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q <= count_d;
      end
      if (acc) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      m_data_q <= {count_d == CapC, count_d == '0,
                   cnt_wide[bst_pkg::CountFieldW-1:0], ok_d};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* hdl/bst_chk.sv */
// Port-level checks for the bounded set table, bound to the top level.
module bst_chk #(
  parameter int unsigned CAPACITY = bst_pkg::DefCapacity
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Input is never blocked when no result waits.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A clear transaction reports success and an empty set.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == bst_pkg::OP_CLEAR)
    |=> m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[6])
    else $error("clear did not empty the set");

  // Empty means a zero count, and the set is never empty and full together.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[6] || (m_axis_tdata[5:1] == 5'd0))
                      && !(m_axis_tdata[6] && m_axis_tdata[7]))
    else $error("inconsistent empty/full flags");

endmodule

bind bounded_set_table bst_chk #(.CAPACITY(CAPACITY)) u_bst_chk (.*);

/* tb/sv/bounded_set_table_tb.sv */
// Self-checking testbench for the bounded set table: stream driver, monitor and set predictor.
`timescale 1ns / 1ps

module bounded_set_table_tb;

  localparam int unsigned CAP = bst_pkg::DefCapacity;
  localparam int IdleLimit = 2000;
  localparam int RandomItems = 2000;
  localparam int PoolSize = 24;

  typedef struct {
    bst_pkg::bst_op_e op;
    logic [31:0]      value;
    bit               hold;   // wait for all outstanding results before sending
  } set_req_t;

  typedef struct {
    bit          ok;
    logic [4:0]  count;
    bit          empty;
    bit          full;
  } set_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] value
  logic [1:0]  s_axis_tuser = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] ok, [5:1] count, [6] empty_res, [7] full_res

  // predictor state: held values in insertion order
  logic [31:0] held_vals[CAP];
  int          held_cnt = 0;

  set_req_t    pending_reqs[$];
  set_result_t expected_results[$];
  set_req_t    next_req;
  set_result_t exp_r;
  logic [31:0] value_pool[PoolSize];

  int presented_cnt = 0;
  int accepted_cnt = 0;
  int idle_cycles = 0;
  int mismatch_cnt = 0;
  int src_gap = 0;
  int sink_stall = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;
  bit fired;

  bounded_set_table u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic set_result_t apply_set_op(bst_pkg::bst_op_e op, logic [31:0] v);
    set_result_t r;
    int slot;
    int k;
    r.ok = 1'b0;
    slot = -1;
    for (k = 0; k < held_cnt; k++) begin
      if (slot < 0 && held_vals[k] == v) slot = k;
    end
    case (op)
      bst_pkg::OP_QUERY: begin
        r.ok = (slot >= 0);
      end
      bst_pkg::OP_INSERT: begin
        if (held_cnt < CAP && slot < 0) begin
          held_vals[held_cnt] = v;
          held_cnt++;
          r.ok = 1'b1;
        end
      end
      bst_pkg::OP_REMOVE: begin
        if (slot >= 0) begin
          for (k = slot; k < held_cnt - 1; k++) held_vals[k] = held_vals[k + 1];
          held_cnt--;
          r.ok = 1'b1;
        end
      end
      default: begin
        held_cnt = 0;
        r.ok = 1'b1;
      end
    endcase
    r.count = 5'(held_cnt);
    r.empty = (held_cnt == 0);
    r.full  = (held_cnt == CAP);
    return r;
  endfunction

  // mostly short gaps, a few long ones; none at all while calm
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return value_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  task automatic add_req(bst_pkg::bst_op_e op, logic [31:0] v, bit hold);
    set_req_t q;
    q.op = op;
    q.value = v;
    q.hold = hold;
    pending_reqs.push_back(q);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (presented_cnt != accepted_cnt) begin
      // transaction still waiting for tready
    end else if (src_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      src_gap--;
    end else if (pending_reqs.size() != 0 &&
                 !(pending_reqs[0].hold && expected_results.size() != 0)) begin
      next_req = pending_reqs.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= next_req.value;
      s_axis_tuser  <= next_req.op;
      presented_cnt++;
      if ($urandom_range(0, 199) == 0) src_calm = !src_calm;
      src_gap = pick_gap(src_calm);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // result sink with random backpressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
      sink_stall = pick_gap(sink_calm);
    end
  end

  // monitor: check results, then predict for newly accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      fired = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        fired = 1'b1;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: tdata=%h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata[0] !== exp_r.ok) begin
            $error("ok: expected %0d, got %0d", exp_r.ok, m_axis_tdata[0]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[5:1] !== exp_r.count) begin
            $error("count: expected %0d, got %0d", exp_r.count, m_axis_tdata[5:1]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[6] !== exp_r.empty) begin
            $error("empty_res: expected %0d, got %0d", exp_r.empty, m_axis_tdata[6]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[7] !== exp_r.full) begin
            $error("full_res: expected %0d, got %0d", exp_r.full, m_axis_tdata[7]);
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fired = 1'b1;
        expected_results.push_back(
          apply_set_op(bst_pkg::bst_op_e'(s_axis_tuser), s_axis_tdata));
        accepted_cnt <= accepted_cnt + 1;
      end
      idle_cycles <= fired ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    int k;
    int blk;
    int mode;
    int r;
    bst_pkg::bst_op_e op;
    logic [31:0] fill_vals[16];

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (k = 4; k < PoolSize; k++) value_pool[k] = $urandom;

    // directed: empty-set corner cases
    add_req(bst_pkg::OP_QUERY, 32'h0, 1'b0);
    add_req(bst_pkg::OP_REMOVE, 32'h5, 1'b0);
    add_req(bst_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b0);

    // fill to capacity with extreme values, duplicate insert halfway
    fill_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002,
                  32'h4000_0000, 32'hBFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000,
                  32'h1234_5678, 32'hEDCB_A987, 32'h7FFF_FFFE, 32'h8000_0001};
    for (k = 0; k < 16; k++) begin
      add_req(bst_pkg::OP_INSERT, fill_vals[k], 1'b0);
      if (k == 7) add_req(bst_pkg::OP_INSERT, 32'h8000_0000, 1'b0);
    end
    add_req(bst_pkg::OP_INSERT, 32'h0000_0003, 1'b0);   // insert into a full set
    add_req(bst_pkg::OP_QUERY, 32'h7FFF_FFFF, 1'b0);
    add_req(bst_pkg::OP_REMOVE, 32'h8000_0000, 1'b0);   // first slot
    add_req(bst_pkg::OP_REMOVE, 32'h8000_0001, 1'b0);   // last slot
    add_req(bst_pkg::OP_REMOVE, 32'h0000_0000, 1'b0);   // middle, shifts the rest
    add_req(bst_pkg::OP_REMOVE, 32'h0000_0000, 1'b0);   // no longer held
    add_req(bst_pkg::OP_QUERY, 32'h0000_0000, 1'b0);
    add_req(bst_pkg::OP_CLEAR, 32'h0, 1'b1);

    // random: blocks of fill-heavy, drain-heavy or balanced traffic over a small pool
    for (blk = 0; blk < RandomItems / 100; blk++) begin
      mode = $urandom_range(0, 2);
      for (k = 0; k < 100; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0:       op = (r < 55) ? bst_pkg::OP_INSERT : (r < 80) ? bst_pkg::OP_QUERY :
                        (r < 99) ? bst_pkg::OP_REMOVE : bst_pkg::OP_CLEAR;
          1:       op = (r < 20) ? bst_pkg::OP_INSERT : (r < 45) ? bst_pkg::OP_QUERY :
                        (r < 98) ? bst_pkg::OP_REMOVE : bst_pkg::OP_CLEAR;
          default: op = (r < 35) ? bst_pkg::OP_INSERT : (r < 65) ? bst_pkg::OP_QUERY :
                        (r < 96) ? bst_pkg::OP_REMOVE : bst_pkg::OP_CLEAR;
        endcase
        add_req(op, pick_value(), (k == 0) && ($urandom_range(0, 3) == 0));
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(pending_reqs.size() == 0 && presented_cnt == accepted_cnt &&
             expected_results.size() == 0) && idle_cycles < IdleLimit) begin
      @(negedge clk_i);
    end
    if (idle_cycles < IdleLimit) repeat (20) @(negedge clk_i);

    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transaction for %0d cycles", IdleLimit);
      $display("FAILED: results differ");
    end else if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bst_pkg.sv
hdl/bst_cell.sv
hdl/bounded_set_table.sv
hdl/bst_chk.sv
tb/sv/bounded_set_table_tb.sv
